>>> src/afp_pkg.sv
// shared types and constants for the amplifier front-panel controller
// no dependencies; imported by every module of the block
package afp_pkg;

	// command codes
	localparam logic [2:0] CMD_POWER  = 3'd0;
	localparam logic [2:0] CMD_CH1    = 3'd1;
	localparam logic [2:0] CMD_CH2    = 3'd2;
	localparam logic [2:0] CMD_NEXT   = 3'd3;
	localparam logic [2:0] CMD_PREV   = 3'd4;
	localparam logic [2:0] CMD_BLINK  = 3'd5;
	localparam logic [2:0] CMD_RAMP   = 3'd6;

	// register indexes on the config port
	localparam logic REG_HOLD  = 1'b0;
	localparam logic REG_TABLE = 1'b1;

	localparam int          CFG_AW      = 4;
	localparam int          CFG_DW      = 64;
	localparam logic [11:0] HOLD_RESET  = 12'd200;
	localparam logic [59:0] TABLE_RESET = 60'h87EA3BF264015D9;
	localparam logic [3:0]  EFFECT_NONE = 4'hF;

	typedef struct packed {
		logic [2:0]  command;
		logic [11:0] press_length;
	} in_item_t;

	typedef struct packed {
		logic [5:0] input_select_lines;
		logic       amp_enable;
		logic [3:0] effect_code;
		logic [9:0] ramp_duty;
		logic       powered;
		logic [3:0] effect_number;
		logic [1:0] blink_flags;
	} out_item_t;

	typedef struct packed {
		logic [11:0] hold_threshold;
		logic [59:0] effect_code_table;
	} cfg_t;

	// one-hot line of a group position; position three selects nothing
	function automatic logic [2:0] group_line(input logic [1:0] pos);
		logic [2:0] r;
		case (pos)
			2'd0:    r = 3'b001;
			2'd1:    r = 3'b010;
			2'd2:    r = 3'b100;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next_pos(input logic [1:0] pos);
		return (pos >= 2'd2) ? 2'd0 : pos + 2'd1;
	endfunction

endpackage

>>> src/amp_front_panel_controller.sv
// top level of the amplifier front-panel controller
// depends on afp_pkg, afp_cfg_regs, afp_core, afp_out_buf
//
// one event transaction is accepted per clock while in_stall is low, and each one
// produces exactly one result, registered in the output buffer; the event's whole effect
// comes from combinational next-state logic in afp_core, so the sustained rate is one
// transaction per cycle for as long as the result side takes them. a two-entry output
// buffer (result register plus skid entry) sits between the sides: in_stall rises only
// once two results are waiting. config registers live at byte address 0 (hold threshold,
// 12 bits) and 8 (effect code table, fifteen 4-bit codes); write them only while idle.
module amp_front_panel_controller #(
	parameter int NUM_EFFECTS = 15,
	parameter int RAMP_MAX    = 1023
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// event channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  afp_pkg::in_item_t           in_item,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output afp_pkg::out_item_t          out_item,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afp_pkg::CFG_AW-1:0]  paddr,
	input  logic [afp_pkg::CFG_DW-1:0]  pwdata,
	output logic [afp_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready
);
	import afp_pkg::*;

	cfg_t      cfg;
	out_item_t result;
	logic      accept;
	logic      buf_full;

	// a transaction is taken whenever the skid entry is free
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	afp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// panel state and next-state logic
	afp_core #(
		.NUM_EFFECTS (NUM_EFFECTS),
		.RAMP_MAX    (RAMP_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.cfg    (cfg),
		.result (result)
	);

	// result register with skid entry
	afp_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

>>> src/afp_cfg_regs.sv
// apb-style register file: hold threshold and effect code table
// depends on afp_pkg
module afp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [afp_pkg::CFG_AW-1:0]    paddr,
	input  logic [afp_pkg::CFG_DW-1:0]    pwdata,
	output logic [afp_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready,
	output afp_pkg::cfg_t                 cfg
);
	import afp_pkg::*;

	logic [11:0] hold_q;
	logic [59:0] table_q;
	logic        wr_en;
	logic        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			table_q <= TABLE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HOLD:  hold_q  <= pwdata[11:0];
				REG_TABLE: table_q <= pwdata[59:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HOLD:  prdata = {52'd0, hold_q};
			REG_TABLE: prdata = {4'd0, table_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.hold_threshold    = hold_q;
	assign cfg.effect_code_table = table_q;

endmodule

>>> src/afp_core.sv
// panel state registers and their next-state logic; builds the result of each event
// depends on afp_pkg
module afp_core #(
	parameter int NUM_EFFECTS = 15,
	parameter int RAMP_MAX    = 1023
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  afp_pkg::in_item_t  item,
	input  afp_pkg::cfg_t      cfg,
	output afp_pkg::out_item_t result
);
	import afp_pkg::*;

	localparam logic [4:0] NUM_E  = 5'(NUM_EFFECTS);
	localparam logic [3:0] LAST_E = 4'(NUM_EFFECTS - 1);
	localparam logic [9:0] DMAX   = 10'(RAMP_MAX);

	logic       power_q, power_n;
	logic [3:0] effect_q, effect_n;
	logic [1:0] pos1_q, pos1_n;
	logic [1:0] pos2_q, pos2_n;
	logic [1:0] blink_q, blink_n;
	logic [5:0] line_q, line_n;
	logic       amp_q, amp_n;
	logic [9:0] duty_q, duty_n;
	logic       rise_q, rise_n;
	logic       fall_q, fall_n;
	logic       ch;
	logic [9:0] duty_up;
	logic [5:0] code_base;

	always_comb begin
		power_n  = power_q;
		effect_n = effect_q;
		pos1_n   = pos1_q;
		pos2_n   = pos2_q;
		blink_n  = blink_q;
		line_n   = line_q;
		amp_n    = amp_q;
		duty_n   = duty_q;
		rise_n   = rise_q;
		fall_n   = fall_q;
		duty_up  = duty_q;
		ch       = (item.command == CMD_CH2);
		case (item.command)
			CMD_POWER: begin
				if (!power_q) begin
					power_n  = 1'b1;
					amp_n    = 1'b1;
					effect_n = 4'd0;
					line_n   = {group_line(pos2_q), group_line(pos1_q)};
					fall_n   = 1'b0;
					rise_n   = 1'b1;
				end else begin
					power_n = 1'b0;
					amp_n   = 1'b0;
					line_n  = 6'd0;
					blink_n = 2'd0;
					pos1_n  = 2'd0;
					pos2_n  = 2'd0;
					rise_n  = 1'b0;
					fall_n  = 1'b1;
				end
			end
			CMD_CH1, CMD_CH2: begin
				if (power_q) begin
					if (blink_q[ch]) begin
						if (item.press_length > cfg.hold_threshold) begin
							blink_n[ch] = 1'b0;
							if (blink_n == 2'd0)
								amp_n = 1'b1;
						end else if (ch) begin
							pos2_n = next_pos(pos2_q);
						end else begin
							pos1_n = next_pos(pos1_q);
						end
						line_n = {group_line(pos2_n), group_line(pos1_n)};
					end else begin
						blink_n[ch] = 1'b1;
						amp_n       = 1'b0;
					end
				end
			end
			CMD_NEXT: begin
				if (power_q)
					effect_n = ({1'b0, effect_q} + 5'd1 >= NUM_E) ? 4'd0 : effect_q + 4'd1;
			end
			CMD_PREV: begin
				if (power_q)
					effect_n = (effect_q == 4'd0 || {1'b0, effect_q} >= NUM_E) ?
						LAST_E : effect_q - 4'd1;
			end
			CMD_BLINK: begin
				line_n = line_q ^ {(blink_q[1] ? group_line(pos2_q) : 3'd0),
				                   (blink_q[0] ? group_line(pos1_q) : 3'd0)};
			end
			CMD_RAMP: begin
				if (rise_q) begin
					if (duty_q < DMAX)
						duty_up = duty_q + 10'd1;
					if (duty_up >= DMAX) begin
						duty_up = DMAX;
						rise_n  = 1'b0;
					end
				end
				duty_n = duty_up;
				if (fall_q) begin
					if (duty_up > 10'd0)
						duty_n = duty_up - 10'd1;
					if (duty_n == 10'd0)
						fall_n = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q  <= 1'b0;
			effect_q <= 4'd0;
			pos1_q   <= 2'd0;
			pos2_q   <= 2'd0;
			blink_q  <= 2'd0;
			line_q   <= 6'd0;
			amp_q    <= 1'b0;
			duty_q   <= 10'd0;
			rise_q   <= 1'b0;
			fall_q   <= 1'b0;
		end else if (accept) begin
			power_q  <= power_n;
			effect_q <= effect_n;
			pos1_q   <= pos1_n;
			pos2_q   <= pos2_n;
			blink_q  <= blink_n;
			line_q   <= line_n;
			amp_q    <= amp_n;
			duty_q   <= duty_n;
			rise_q   <= rise_n;
			fall_q   <= fall_n;
		end
	end

	// result shows the state after the event
	assign code_base                 = {effect_n, 2'b00};
	assign result.input_select_lines = line_n;
	assign result.amp_enable         = amp_n;
	assign result.effect_code        = (effect_n == EFFECT_NONE) ? 4'd0 :
		cfg.effect_code_table[code_base +: 4];
	assign result.ramp_duty          = duty_n;
	assign result.powered            = power_n;
	assign result.effect_number      = effect_n;
	assign result.blink_flags        = blink_n;

endmodule

>>> src/afp_out_buf.sv
// two-entry output buffer: result register plus skid entry
// depends on afp_pkg
module afp_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  afp_pkg::out_item_t push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output afp_pkg::out_item_t out_item
);
	import afp_pkg::*;

	out_item_t main_q;
	out_item_t skid_q;
	logic      main_v_q;
	logic      skid_v_q;
	logic      pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q)
				skid_v_q <= 1'b1;
			else
				main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (main_v_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule

>>> src/afp_checker.sv
// port-level assertions for the amplifier front-panel controller, and their bind
// depends on afp_pkg and amp_front_panel_controller
module afp_checker #(
	parameter int NUM_EFFECTS = 15,
	parameter int RAMP_MAX    = 1023
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input afp_pkg::out_item_t out_item
);
	import afp_pkg::*;

	// stall only once a result is already waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid) else $error("input stalled with no result waiting");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_effect_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, out_item.effect_number} < 5'(NUM_EFFECTS))
		else $error("effect number out of range");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.ramp_duty <= 10'(RAMP_MAX))
		else $error("ramp duty above maximum");

	// switched off means no blinking, no lines and amplifier off
	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.powered |->
			out_item.blink_flags == 2'd0 && !out_item.amp_enable &&
			out_item.input_select_lines == 6'd0)
		else $error("panel active while switched off");

endmodule

bind amp_front_panel_controller afp_checker #(
	.NUM_EFFECTS (NUM_EFFECTS),
	.RAMP_MAX    (RAMP_MAX)
) u_afp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
